/* sv/mbc3_pkg.sv */
// Shared types, region codes and constants for the MBC3 bank mapper and decoder.
package mbc3_pkg;

    localparam int ADDR_W      = 16;
    localparam int DATA_W      = 8;
    localparam int TARGET_W    = 4;
    localparam int ROM_BANK_W  = 7;
    localparam int RAM_SEL_W   = 4;
    localparam int CLK_REG_W   = 3;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 24;

    localparam logic [TARGET_W-1:0] T_NONE    = 4'd0;
    localparam logic [TARGET_W-1:0] T_ROM0    = 4'd1;
    localparam logic [TARGET_W-1:0] T_ROMN    = 4'd2;
    localparam logic [TARGET_W-1:0] T_VRAM    = 4'd3;
    localparam logic [TARGET_W-1:0] T_CARTRAM = 4'd4;
    localparam logic [TARGET_W-1:0] T_CLOCK   = 4'd5;
    localparam logic [TARGET_W-1:0] T_WRAM0   = 4'd6;
    localparam logic [TARGET_W-1:0] T_WRAMN   = 4'd7;
    localparam logic [TARGET_W-1:0] T_OAM     = 4'd8;
    localparam logic [TARGET_W-1:0] T_IO      = 4'd9;
    localparam logic [TARGET_W-1:0] T_HRAM    = 4'd10;
    localparam logic [TARGET_W-1:0] T_IE      = 4'd11;
    localparam logic [TARGET_W-1:0] T_UNUSED  = 4'd12;

    localparam logic [1:0] REG_RAM_ENABLE = 2'd0;
    localparam logic [1:0] REG_ROM_BANK   = 2'd1;
    localparam logic [1:0] REG_RAM_SELECT = 2'd2;
    localparam logic [1:0] REG_LATCH      = 2'd3;

    localparam logic [3:0]          RAM_ENABLE_KEY  = 4'hA;
    localparam logic [RAM_SEL_W-1:0] CART_SEL_LIMIT = 4'h4;
    localparam logic [RAM_SEL_W-1:0] CLK_SEL_LOW    = 4'h8;
    localparam logic [RAM_SEL_W-1:0] CLK_SEL_LIMIT  = 4'hD;
    localparam logic [DATA_W-1:0]   LATCH_ARM       = 8'h00;
    localparam logic [DATA_W-1:0]   LATCH_FIRE      = 8'h01;

    localparam logic [ADDR_W-1:0] ECHO_END   = 16'hFE00;
    localparam logic [7:0]        OAM_END    = 8'hA0;
    localparam logic [ADDR_W-1:0] IE_ADDR    = 16'hFFFF;

    typedef struct packed {
        logic              opcode;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
    } in_item_t;

    typedef struct packed {
        logic [TARGET_W-1:0]   target;
        logic                  write_strobe;
        logic                  mirror_read;
        logic [ROM_BANK_W-1:0] rom_bank_index;
        logic [RAM_SEL_W-1:0]  ram_bank;
        logic                  ram_enabled;
        logic [CLK_REG_W-1:0]  clock_register;
        logic                  latch_pulse;
    } res_item_t;

    typedef struct packed {
        logic advance;
    } pipe_ctl_t;

endpackage

/* sv/mbc3_in_reg.sv */
// Input request register with stream handshake.
module mbc3_in_reg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mbc3_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tuser,
    input  mbc3_pkg::pipe_ctl_t             ctl,
    output logic                            valid,
    output mbc3_pkg::in_item_t              item
);

    logic               valid_reg;
    logic               valid_next;
    mbc3_pkg::in_item_t item_reg;
    logic               accept;

    assign s_tready   = !valid_reg || ctl.advance;
    assign accept     = s_tvalid && s_tready;
    assign valid_next = accept || (valid_reg && !ctl.advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.opcode     <= s_tuser;
            item_reg.address    <= s_tdata[15:0];
            item_reg.write_data <= s_tdata[23:16];
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

/* sv/mbc3_core.sv */
// Controller registers and address decode for one bus request.
module mbc3_core (
    input  logic                clk,
    input  logic                rst_n,
    input  mbc3_pkg::pipe_ctl_t ctl,
    input  mbc3_pkg::in_item_t  item,
    output mbc3_pkg::res_item_t result
);

    logic                                ram_enable_reg;
    logic                                ram_enable_next;
    logic [mbc3_pkg::ROM_BANK_W-1:0]     rom_bank_reg;
    logic [mbc3_pkg::ROM_BANK_W-1:0]     rom_bank_next;
    logic [mbc3_pkg::RAM_SEL_W-1:0]      ram_select_reg;
    logic [mbc3_pkg::RAM_SEL_W-1:0]      ram_select_next;
    logic [mbc3_pkg::DATA_W-1:0]         last_latch_reg;
    logic [mbc3_pkg::DATA_W-1:0]         last_latch_next;

    logic                                wr;
    logic [mbc3_pkg::ADDR_W-1:0]         a;
    logic [mbc3_pkg::DATA_W-1:0]         d;
    logic [mbc3_pkg::ROM_BANK_W-1:0]     bank_raw;
    logic [mbc3_pkg::TARGET_W-1:0]       cart_tgt;
    logic [mbc3_pkg::TARGET_W-1:0]       tgt;
    logic                                strobe;
    logic                                mirror;
    logic                                latch;
    logic [mbc3_pkg::RAM_SEL_W-1:0]      clk_sel;

    assign wr       = item.opcode;
    assign a        = item.address;
    assign d        = item.write_data;
    assign bank_raw = d[mbc3_pkg::ROM_BANK_W-1:0];
    assign clk_sel  = ram_select_reg - mbc3_pkg::CLK_SEL_LOW;

    always_comb
    begin
        if (!ram_enable_reg)
        begin
            cart_tgt = mbc3_pkg::T_NONE;
        end
        else if (ram_select_reg < mbc3_pkg::CART_SEL_LIMIT)
        begin
            cart_tgt = mbc3_pkg::T_CARTRAM;
        end
        else if (ram_select_reg >= mbc3_pkg::CLK_SEL_LOW
                 && ram_select_reg < mbc3_pkg::CLK_SEL_LIMIT)
        begin
            cart_tgt = mbc3_pkg::T_CLOCK;
        end
        else
        begin
            cart_tgt = mbc3_pkg::T_NONE;
        end
    end

    always_comb
    begin
        ram_enable_next = ram_enable_reg;
        rom_bank_next   = rom_bank_reg;
        ram_select_next = ram_select_reg;
        last_latch_next = last_latch_reg;
        tgt             = mbc3_pkg::T_NONE;
        strobe          = 1'b0;
        mirror          = 1'b0;
        latch           = 1'b0;

        if (!a[15])
        begin
            tgt = a[14] ? mbc3_pkg::T_ROMN : mbc3_pkg::T_ROM0;
            if (wr)
            begin
                case (a[14:13])
                    mbc3_pkg::REG_RAM_ENABLE:
                    begin
                        ram_enable_next = (d[3:0] == mbc3_pkg::RAM_ENABLE_KEY);
                    end
                    mbc3_pkg::REG_ROM_BANK:
                    begin
                        rom_bank_next = (bank_raw == '0) ? '0 : bank_raw - 1'b1;
                    end
                    mbc3_pkg::REG_RAM_SELECT:
                    begin
                        ram_select_next = d[mbc3_pkg::RAM_SEL_W-1:0];
                    end
                    default:
                    begin
                        latch = (d == mbc3_pkg::LATCH_FIRE)
                                && (last_latch_reg == mbc3_pkg::LATCH_ARM);
                        last_latch_next = d;
                    end
                endcase
            end
        end
        else
        begin
            case (a[14:13])
                2'b00:
                begin
                    tgt    = mbc3_pkg::T_VRAM;
                    strobe = wr;
                end
                2'b01:
                begin
                    tgt    = cart_tgt;
                    strobe = wr && (cart_tgt != mbc3_pkg::T_NONE);
                end
                2'b10:
                begin
                    tgt    = a[12] ? mbc3_pkg::T_WRAMN : mbc3_pkg::T_WRAM0;
                    strobe = wr;
                end
                default:
                begin
                    if (a < mbc3_pkg::ECHO_END)
                    begin
                        tgt    = wr ? mbc3_pkg::T_NONE : mbc3_pkg::T_WRAM0;
                        mirror = !wr;
                    end
                    else if (!a[8])
                    begin
                        if (a[7:0] < mbc3_pkg::OAM_END)
                        begin
                            tgt    = mbc3_pkg::T_OAM;
                            strobe = wr;
                        end
                        else
                        begin
                            tgt = mbc3_pkg::T_UNUSED;
                        end
                    end
                    else if (!a[7])
                    begin
                        tgt    = mbc3_pkg::T_IO;
                        strobe = wr;
                    end
                    else if (a == mbc3_pkg::IE_ADDR)
                    begin
                        tgt    = mbc3_pkg::T_IE;
                        strobe = wr;
                    end
                    else
                    begin
                        tgt    = mbc3_pkg::T_HRAM;
                        strobe = wr;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_enable_reg <= 1'b0;
            rom_bank_reg   <= '0;
            ram_select_reg <= '0;
            last_latch_reg <= '0;
        end
        else if (ctl.advance)
        begin
            ram_enable_reg <= ram_enable_next;
            rom_bank_reg   <= rom_bank_next;
            ram_select_reg <= ram_select_next;
            last_latch_reg <= last_latch_next;
        end
    end

    assign result.target         = tgt;
    assign result.write_strobe   = strobe;
    assign result.mirror_read    = mirror;
    assign result.rom_bank_index = rom_bank_next;
    assign result.ram_bank       = ram_select_next;
    assign result.ram_enabled    = ram_enable_next;
    assign result.clock_register = (tgt == mbc3_pkg::T_CLOCK)
                                   ? clk_sel[mbc3_pkg::CLK_REG_W-1:0] : '0;
    assign result.latch_pulse    = latch;

endmodule

/* sv/mbc3_out_reg.sv */
// Result register with stream handshake and pipeline advance control.
module mbc3_out_reg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  mbc3_pkg::res_item_t             result,
    output mbc3_pkg::pipe_ctl_t             ctl,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mbc3_pkg::M_TDATA_W-1:0]  m_tdata
);

    logic                valid_reg;
    logic                valid_next;
    mbc3_pkg::res_item_t res_reg;
    logic                advance;

    assign advance    = in_valid && (!valid_reg || m_tready);
    assign valid_next = advance || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= result;
        end
    end

    assign ctl.advance = advance;
    assign m_tvalid    = valid_reg;
    assign m_tdata     = {2'b00,
                          res_reg.latch_pulse,
                          res_reg.clock_register,
                          res_reg.ram_enabled,
                          res_reg.ram_bank,
                          res_reg.rom_bank_index,
                          res_reg.mirror_read,
                          res_reg.write_strobe,
                          res_reg.target};

endmodule

/* sv/mbc3_bank_mapper_decoder.sv */
// Top level of the MBC3 bank mapper and 16-bit bus address decoder.
// A request passes from the input register through the decode into the result register.
// Throughput: one request per cycle while m_tready is high; both registers keep it going.
// Controller registers change as a request moves into the result register.
// Reset (rst_n low, asynchronous): pipeline empty, RAM disabled, ROM bank 1,
// select 0, last latch byte 0.
module mbc3_bank_mapper_decoder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mbc3_pkg::S_TDATA_W-1:0]  s_tdata,  // address[15:0], write_data[23:16]
    input  logic                            s_tuser,  // opcode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mbc3_pkg::M_TDATA_W-1:0]  m_tdata   // target[3:0], write_strobe[4],
                                                      // mirror_read[5], rom_bank_index[12:6],
                                                      // ram_bank[16:13], ram_enabled[17],
                                                      // clock_register[20:18],
                                                      // latch_pulse[21], zero[23:22]
);

    mbc3_pkg::pipe_ctl_t ctl;
    mbc3_pkg::in_item_t  item;
    mbc3_pkg::res_item_t result;
    logic                item_valid;

    mbc3_in_reg u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .ctl      (ctl),
        .valid    (item_valid),
        .item     (item)
    );

    mbc3_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .item   (item),
        .result (result)
    );

    mbc3_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item_valid),
        .result   (result),
        .ctl      (ctl),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* sv/mbc3_checker.sv */
// Port-level assertions for the MBC3 bank mapper and decoder, bound to the top level.
module mbc3_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [mbc3_pkg::M_TDATA_W-1:0]  m_tdata
);

    logic [mbc3_pkg::TARGET_W-1:0] tgt;

    assign tgt = m_tdata[3:0];

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("request refused with empty result register");

    a_strobe_target: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[4] |-> !(tgt == mbc3_pkg::T_NONE || tgt == mbc3_pkg::T_UNUSED
                                     || tgt == mbc3_pkg::T_ROM0 || tgt == mbc3_pkg::T_ROMN))
        else $error("write strobe on a region without a store");

    a_mirror_wram0: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[5] |-> tgt == mbc3_pkg::T_WRAM0 && !m_tdata[4] && !m_tdata[21])
        else $error("echo read not served from work RAM bank 0");

    a_clock_reg: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && tgt != mbc3_pkg::T_CLOCK |-> m_tdata[20:18] == '0)
        else $error("clock register index outside clock target");

endmodule

bind mbc3_bank_mapper_decoder mbc3_checker u_chk (.*);
